// ===== rtl/swr_pkg.sv =====
package swr_pkg;

  localparam int DEF_MAX_WINDOW  = 32;
  localparam int DEF_MAX_PAYLOAD = 1500;

  localparam int SEQ_W      = 32;
  localparam int LEN_W      = 11;
  localparam int WIN_W      = 6;
  localparam int SLOT_OUT_W = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [1:0] PKT_DATA = 2'd0;
  localparam logic [1:0] PKT_END  = 2'd1;

  localparam logic [1:0] RES_STORE   = 2'd0;
  localparam logic [1:0] RES_DELIVER = 2'd1;
  localparam logic [1:0] RES_ACK     = 2'd2;
  localparam logic [1:0] RES_END_ACK = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_MODE = 1'd1;

  typedef struct packed {
    logic [1:0]       packet_kind;
    logic [SEQ_W-1:0] seq_number;
    logic [LEN_W-1:0] payload_length;
    logic             checksum_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            result_kind;
    logic [SEQ_W-1:0]      result_seq;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [LEN_W-1:0]      slot_length;
    logic                  session_done;
    logic                  last_result;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic store;
    logic ack;
    logic dlv_read;
    logic dlv_emit;
    logic end_ack;
  } swr_cmd_t;

  typedef struct packed {
    logic out_ok;
    logic chk_ok;
    logic is_data;
    logic is_end;
    logic in_win;
    logic in_order;
    logic ack_mode;
    logic more;
  } swr_stat_t;

endpackage

// ===== rtl/swr_ram.sv =====
module swr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/swr_ctrl.sv =====
module swr_ctrl
  import swr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      cfg_ready,
  input  swr_stat_t stat,
  output swr_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EVAL     = 3'd1;
  localparam logic [2:0] S_STORE    = 3'd2;
  localparam logic [2:0] S_ACK      = 3'd3;
  localparam logic [2:0] S_DLV_RD   = 3'd4;
  localparam logic [2:0] S_DLV_EMIT = 3'd5;
  localparam logic [2:0] S_END      = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        priority if (!stat.chk_ok) begin
          state_nxt = S_IDLE;
        end else if (stat.is_data) begin
          if (stat.in_win) begin
            state_nxt = S_STORE;
          end else if (!stat.ack_mode) begin
            state_nxt = S_ACK;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (stat.is_end) begin
          state_nxt = S_END;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_STORE: begin
        if (stat.out_ok) begin
          if (stat.ack_mode || !stat.in_order) begin
            state_nxt = S_ACK;
          end else begin
            state_nxt = S_DLV_RD;
          end
        end
      end
      S_ACK: begin
        if (stat.out_ok) begin
          if (stat.ack_mode && stat.in_order) begin
            state_nxt = S_DLV_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DLV_RD: begin
        state_nxt = S_DLV_EMIT;
      end
      S_DLV_EMIT: begin
        if (stat.out_ok) begin
          if (stat.more) begin
            state_nxt = S_DLV_EMIT;
          end else if (stat.ack_mode) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_ACK;
          end
        end
      end
      S_END: begin
        if (stat.out_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !in_valid;

  assign cmd.capture  = (state_r == S_IDLE) && in_valid;
  assign cmd.eval     = (state_r == S_EVAL);
  assign cmd.store    = (state_r == S_STORE);
  assign cmd.ack      = (state_r == S_ACK);
  assign cmd.dlv_read = (state_r == S_DLV_RD);
  assign cmd.dlv_emit = (state_r == S_DLV_EMIT);
  assign cmd.end_ack  = (state_r == S_END);

endmodule

// ===== rtl/swr_datapath.sv =====
module swr_datapath
  import swr_pkg::*;
#(
  parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  swr_cmd_t              cmd,
  output swr_stat_t             stat,
  input  logic                  out_stall,
  output logic                  out_valid,
  output out_item_t             out_item
);

  localparam int NSLOT  = MAX_WINDOW + 1;
  localparam int SLOT_W = $clog2(NSLOT);

  logic [WIN_W-1:0]  window_r, window_nxt;
  logic              mode_r, mode_nxt;
  logic [SEQ_W-1:0]  exp_seq_r, exp_seq_nxt;
  logic [SLOT_W-1:0] exp_slot_r, exp_slot_nxt;
  logic [NSLOT-1:0]  arrived_r, arrived_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic [1:0]        kind_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [LEN_W-1:0]  len_r;
  logic              ok_r;
  logic [SLOT_W-1:0] slot_r;
  logic              in_order_r;
  logic [SLOT_W-1:0] cnt_r;

  logic [WIN_W-1:0]  w_full;
  logic [SLOT_W-1:0] w;
  logic [SLOT_W:0]   wp1;
  logic [SLOT_W-1:0] base_slot;
  logic [SEQ_W-1:0]  offset;
  logic              in_win;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W:0]   slot_calc;
  logic [SLOT_W:0]   slot_inc;
  logic [SLOT_W-1:0] nxt_slot;
  logic [SLOT_W:0]   cnt_inc;
  logic              more;
  logic              done;
  logic              out_ok;
  logic              st_fire, ack_fire, dlv_fire, end_fire;
  logic [LEN_W-1:0]  len_clamp;
  logic [LEN_W-1:0]  ram_rdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;

  always_comb begin
    if (window_r == '0) begin
      w_full = WIN_W'(1);
    end else if (32'(window_r) > MAX_WINDOW) begin
      w_full = WIN_W'(MAX_WINDOW);
    end else begin
      w_full = window_r;
    end
  end

  assign w         = w_full[SLOT_W-1:0];
  assign wp1       = {1'b0, w} + (SLOT_W+1)'(1);
  assign base_slot = (exp_slot_r > w) ? '0 : exp_slot_r;
  assign offset    = seq_r - exp_seq_r;
  assign in_win    = (offset < SEQ_W'(w));
  assign slot_sum  = {1'b0, base_slot} + {1'b0, offset[SLOT_W-1:0]};
  assign slot_calc = (slot_sum >= wp1) ? (slot_sum - wp1) : slot_sum;
  assign slot_inc  = {1'b0, exp_slot_r} + (SLOT_W+1)'(1);
  assign nxt_slot  = (slot_inc == wp1) ? '0 : slot_inc[SLOT_W-1:0];
  assign cnt_inc   = {1'b0, cnt_r} + (SLOT_W+1)'(1);
  assign more      = arrived_r[nxt_slot] && (cnt_inc < {1'b0, w});
  assign done      = (seq_r == exp_seq_r);

  assign out_ok   = !out_valid_r || !out_stall;
  assign st_fire  = cmd.store && out_ok;
  assign ack_fire = cmd.ack && out_ok;
  assign dlv_fire = cmd.dlv_emit && out_ok;
  assign end_fire = cmd.end_ack && out_ok;

  assign len_clamp = (32'(in_item.payload_length) > MAX_PAYLOAD) ?
                     LEN_W'(MAX_PAYLOAD) : in_item.payload_length;

  always_comb begin
    window_nxt   = window_r;
    mode_nxt     = mode_r;
    exp_seq_nxt  = exp_seq_r;
    exp_slot_nxt = exp_slot_r;
    arrived_nxt  = arrived_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIN_LEN: begin
          window_nxt   = cfg_data;
          exp_seq_nxt  = '0;
          exp_slot_nxt = '0;
          arrived_nxt  = '0;
        end
        CFG_ACK_MODE: begin
          mode_nxt = cfg_data[0];
        end
        default: begin
        end
      endcase
    end
    if (cmd.eval && ok_r && (kind_r == PKT_DATA)) begin
      exp_slot_nxt = base_slot;
    end
    if (st_fire) begin
      arrived_nxt[slot_r] = 1'b1;
    end
    if (dlv_fire) begin
      arrived_nxt[exp_slot_r] = 1'b0;
      exp_seq_nxt             = exp_seq_r + SEQ_W'(1);
      exp_slot_nxt            = nxt_slot;
    end
    if (end_fire && done) begin
      exp_seq_nxt  = '0;
      exp_slot_nxt = '0;
      arrived_nxt  = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    priority if (st_fire) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = '{RES_STORE, seq_r, SLOT_OUT_W'(slot_r), len_r, 1'b0, 1'b0};
    end else if (ack_fire) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = '{RES_ACK, (mode_r ? seq_r : exp_seq_r), '0, '0, 1'b0,
                        !(mode_r && in_order_r)};
    end else if (dlv_fire) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = '{RES_DELIVER, exp_seq_r, SLOT_OUT_W'(exp_slot_r), ram_rdata,
                        1'b0, (mode_r && !more)};
    end else if (end_fire) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = '{RES_END_ACK, seq_r, '0, '0, done, 1'b1};
    end else begin
      out_item_nxt = out_item_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WIN_W'(1);
      mode_r      <= 1'b0;
      exp_seq_r   <= '0;
      exp_slot_r  <= '0;
      arrived_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      window_r    <= window_nxt;
      mode_r      <= mode_nxt;
      exp_seq_r   <= exp_seq_nxt;
      exp_slot_r  <= exp_slot_nxt;
      arrived_r   <= arrived_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (cmd.capture) begin
      kind_r <= in_item.packet_kind;
      seq_r  <= in_item.seq_number;
      len_r  <= len_clamp;
      ok_r   <= in_item.checksum_ok;
    end
    if (cmd.eval) begin
      slot_r     <= slot_calc[SLOT_W-1:0];
      in_order_r <= (offset == '0);
      cnt_r      <= '0;
    end
    if (dlv_fire) begin
      cnt_r <= cnt_inc[SLOT_W-1:0];
    end
  end

  assign ram_re    = cmd.dlv_read || dlv_fire;
  assign ram_raddr = cmd.dlv_read ? exp_slot_r : nxt_slot;

  swr_ram #(
    .WIDTH (LEN_W),
    .DEPTH (NSLOT)
  ) u_len_ram (
    .clk     (clk),
    .wr_en   (st_fire),
    .wr_addr (slot_r),
    .wr_data (len_r),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign stat.out_ok   = out_ok;
  assign stat.chk_ok   = ok_r;
  assign stat.is_data  = (kind_r == PKT_DATA);
  assign stat.is_end   = (kind_r == PKT_END);
  assign stat.in_win   = in_win;
  assign stat.in_order = in_order_r;
  assign stat.ack_mode = mode_r;
  assign stat.more     = more;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/sliding_window_receiver.sv =====
// Receive side of a selective-repeat sliding window. Packet headers come in one at a time,
// and each one turns into a short, possibly empty, sequence of store, deliver, acknowledge and
// end-acknowledge transfers on the result channel, the last flagged by last_result. An item is
// captured, then checked in the evaluate state, then results go out one per cycle while the
// output is not stalled, with a length read before the first delivery when an in-order packet
// releases stored slots. The worst case is an in-order packet releasing a full window, set by
// the delivery loop, which walks one slot per cycle when not stalled through the single read
// port of the slot length memory. The slot bitmap is cleared by reset, a window length write
// and an end packet matching the expected sequence number, so no clearing pass is needed.
// Configuration writes are taken only while no packet is in work or being offered.
module sliding_window_receiver
  import swr_pkg::*;
#(
  parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  swr_cmd_t  cmd;
  swr_stat_t stat;
  logic      cfg_we;

  assign cfg_we = cfg_valid && cfg_ready;

  swr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  swr_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("A second packet was taken while one was in work.");

  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.store, cmd.ack, cmd.dlv_emit, cmd.end_ack}))
    else $error("More than one result source is active.");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("A result appeared with no packet in work.");
`endif

endmodule
